/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the attitude PID/mixer block.
// Used by files that include this header; expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* hw/rtl/qapm_pkg.sv */
`timescale 1ns / 1ps
// Types and constants for the quadrotor attitude PID and X mixer.
// No dependencies; imported by qapm_axis and the top level.
package qapm_pkg;

    localparam int ANG_W   = 16;  // Q8.8 angle / rate
    localparam int ERR_W   = 17;  // Q9.8 angle error
    localparam int GAIN_W  = 16;  // unsigned Q8.8 gain
    localparam int THR_W   = 12;
    localparam int MODE_W  = 3;
    localparam int MOTOR_W = 11;
    localparam int INTEG_W = 32;  // Q16.16 integral
    localparam int LIM_W   = 27;  // throttle * 2^15
    localparam int AXIS_W  = 35;  // Q19.16 axis output
    localparam int MIX_W   = 38;  // Q22.16 mixer sum
    localparam int CFG_IDX_W = 3;

    localparam logic [THR_W-1:0]   THROTTLE_MIN = THR_W'(100);
    localparam logic [MOTOR_W-1:0] MOTOR_MAX    = MOTOR_W'(2000);

    localparam logic [MODE_W-1:0] MODE_FLY_A = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_FLY_B = MODE_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_KP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_KI  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_KD  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_KP = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_KI = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_KD = CFG_IDX_W'(5);

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_gains;

    // Per-axis pipeline control from the top level.
    typedef struct packed {
        logic prod_load;   // product stage advances
        logic integ_load;  // valid flying beat leaves the product stage
    } t_axis_ctl;

    // Mixer sum to motor compare: <= 0 gives 0, else integer part capped.
    function automatic logic [MOTOR_W-1:0] motor_of(input logic signed [MIX_W-1:0] q);
        logic signed [MIX_W-17:0] whole;
        logic [MOTOR_W-1:0]       res;
        whole = q[MIX_W-1:16];
        if (q <= 0) begin
            res = '0;
        end else if (whole > $signed({{(MIX_W-16-MOTOR_W){1'b0}}, MOTOR_MAX})) begin
            res = MOTOR_MAX;
        end else begin
            res = whole[MOTOR_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/qapm_axis.sv */
`timescale 1ns / 1ps
// One attitude axis: registered gain products, then integral update/clamp
// and the axis sum. Depends on qapm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qapm_axis (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  qapm_pkg::t_axis_ctl                     i_ctl,
    input  qapm_pkg::t_gains                        i_gains,
    input  logic signed [qapm_pkg::ERR_W-1:0]       i_err,
    input  logic signed [qapm_pkg::ANG_W-1:0]       i_rate,
    input  logic        [qapm_pkg::LIM_W-1:0]       i_limit,
    output logic signed [qapm_pkg::AXIS_W-1:0]      o_axis
);
    import qapm_pkg::*;

    localparam int PKP_W = GAIN_W + 1 + ERR_W;
    localparam int PKD_W = GAIN_W + 1 + ANG_W;
    localparam int SUM_W = PKP_W + 1;

    logic signed [PKP_W-1:0]   r_p_kp, n_p_kp;
    logic signed [PKP_W-1:0]   r_p_ki, n_p_ki;
    logic signed [PKD_W-1:0]   r_p_kd, n_p_kd;
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   lim_s;

    assign n_p_kp = $signed({1'b0, i_gains.kp}) * i_err;
    assign n_p_ki = $signed({1'b0, i_gains.ki}) * i_err;
    assign n_p_kd = $signed({1'b0, i_gains.kd}) * i_rate;

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_load) begin
            r_p_kp <= n_p_kp;
            r_p_ki <= n_p_ki;
            r_p_kd <= n_p_kd;
        end
    end

    assign lim_s = $signed({{(SUM_W-LIM_W){1'b0}}, i_limit});

    always_comb begin
        sum = $signed({{(SUM_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ})
            + $signed({r_p_ki[PKP_W-1], r_p_ki});
        if (sum > lim_s) begin
            n_integ = lim_s[INTEG_W-1:0];
        end else if (sum < -lim_s) begin
            n_integ = INTEG_W'(-lim_s);
        end else begin
            n_integ = sum[INTEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_ctl.integ_load) begin
            r_integ <= n_integ;
        end
    end

    assign o_axis = $signed({{(AXIS_W-PKP_W){r_p_kp[PKP_W-1]}}, r_p_kp})
                  + $signed({{(AXIS_W-INTEG_W){n_integ[INTEG_W-1]}}, n_integ})
                  + $signed({{(AXIS_W-PKD_W){r_p_kd[PKD_W-1]}}, r_p_kd});

    `ASSERT_CLKD(a_integ_bound, i_ctl.integ_load |=> (r_integ <= $past(lim_s) && r_integ >= -$past(lim_s)), "integral outside clamp limit")
    `ASSERT_CLKD(a_integ_hold, !i_ctl.integ_load |=> $stable(r_integ), "integral changed without a flying beat")

endmodule

/* hw/rtl/quadrotor_attitude_pid_mixer_unit.sv */
`timescale 1ns / 1ps
// Top level of the roll/pitch attitude PID with X-layout motor mixer.
// Depends on qapm_pkg, qapm_axis and assert_macros.svh.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one sensor sample per beat.
//   Output channel: o_out_valid / i_out_stall carry four motor commands per
//   beat, exactly one result beat per input beat, in order.
//   Config channel: i_cfg_valid / o_cfg_ready, index 0..5 selects roll kp,
//   ki, kd, pitch kp, ki, kd; other indexes are dropped. Always ready; write
//   only while the pipeline is empty.
//   Path: an input beat passes the input register, the gain product register
//   and the result register before its result beat is valid. Throughput: one
//   beat per cycle while the output is not stalled; the integral loop closes
//   within the final stage, so samples may follow back to back.
//   Stall: each stage moves when the next one is empty or moving, so a
//   stalled result holds while up to two more samples are taken in; o_in_stall
//   rises only when all three stages are full.
//   Reset: gains and both integrals clear to zero, pipeline empties.
//   Motors are 0 unless mode is 1 or 4 and throttle is above 100; while they
//   are off the integrals also stay untouched.
`include "assert_macros.svh"
module quadrotor_attitude_pid_mixer_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [qapm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [qapm_pkg::GAIN_W-1:0]           i_cfg_data,
    // sample in
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [qapm_pkg::ANG_W-1:0]     i_roll_measured,
    input  logic signed [qapm_pkg::ANG_W-1:0]     i_pitch_measured,
    input  logic signed [qapm_pkg::ANG_W-1:0]     i_roll_setpoint,
    input  logic signed [qapm_pkg::ANG_W-1:0]     i_pitch_setpoint,
    input  logic signed [qapm_pkg::ANG_W-1:0]     i_roll_rate,
    input  logic signed [qapm_pkg::ANG_W-1:0]     i_pitch_rate,
    input  logic [qapm_pkg::THR_W-1:0]            i_throttle,
    input  logic [qapm_pkg::MODE_W-1:0]           i_mode,
    // motors out
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [qapm_pkg::MOTOR_W-1:0]          o_motor_front_left,
    output logic [qapm_pkg::MOTOR_W-1:0]          o_motor_rear_left,
    output logic [qapm_pkg::MOTOR_W-1:0]          o_motor_rear_right,
    output logic [qapm_pkg::MOTOR_W-1:0]          o_motor_front_right
);
    import qapm_pkg::*;

    t_gains r_roll_g, r_pitch_g;

    logic r_v0, r_v1, r_v2;
    logic adv0, adv1, adv2;

    logic signed [ERR_W-1:0] r_roll_err, r_pitch_err;
    logic signed [ANG_W-1:0] r_roll_rate, r_pitch_rate;
    logic [THR_W-1:0]        r_thr0, r_thr1;
    logic                    r_fly0, r_fly1;
    logic                    n_fly;

    t_axis_ctl               axis_ctl;
    logic signed [AXIS_W-1:0] roll_out, pitch_out;
    logic signed [MIX_W-1:0]  thr_q, roll_q, pitch_q;
    logic [MOTOR_W-1:0] r_m_fl, r_m_rl, r_m_rr, r_m_fr;

    logic pipe_full, motors_in_range, motors_off;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_g  <= '0;
            r_pitch_g <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROLL_KP:  r_roll_g.kp  <= i_cfg_data;
                CFG_ROLL_KI:  r_roll_g.ki  <= i_cfg_data;
                CFG_ROLL_KD:  r_roll_g.kd  <= i_cfg_data;
                CFG_PITCH_KP: r_pitch_g.kp <= i_cfg_data;
                CFG_PITCH_KI: r_pitch_g.ki <= i_cfg_data;
                CFG_PITCH_KD: r_pitch_g.kd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    assign adv2 = !r_v2 || !i_out_stall;
    assign adv1 = !r_v1 || adv2;
    assign adv0 = !r_v0 || adv1;
    assign o_in_stall = !adv0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv0) r_v0 <= i_in_valid;
            if (adv1) r_v1 <= r_v0;
            if (adv2) r_v2 <= r_v1;
        end
    end

    // ---------------- stage 0: input register ----------------
    assign n_fly = (i_mode == MODE_FLY_A || i_mode == MODE_FLY_B)
                && (i_throttle > THROTTLE_MIN);

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_roll_err   <= ERR_W'(i_roll_measured) - ERR_W'(i_roll_setpoint);
            r_pitch_err  <= ERR_W'(i_pitch_measured) - ERR_W'(i_pitch_setpoint);
            r_roll_rate  <= i_roll_rate;
            r_pitch_rate <= i_pitch_rate;
            r_thr0       <= i_throttle;
            r_fly0       <= n_fly;
        end
    end

    // ---------------- stage 1: products ----------------
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_thr1 <= r_thr0;
            r_fly1 <= r_fly0;
        end
    end

    assign axis_ctl.prod_load  = adv1;
    assign axis_ctl.integ_load = adv2 && r_v1 && r_fly1;

    qapm_axis u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (axis_ctl),
        .i_gains (r_roll_g),
        .i_err   (r_roll_err),
        .i_rate  (r_roll_rate),
        .i_limit ({r_thr1, 15'b0}),
        .o_axis  (roll_out)
    );

    qapm_axis u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (axis_ctl),
        .i_gains (r_pitch_g),
        .i_err   (r_pitch_err),
        .i_rate  (r_pitch_rate),
        .i_limit ({r_thr1, 15'b0}),
        .o_axis  (pitch_out)
    );

    // ---------------- stage 2: mixer and result register ----------------
    assign thr_q   = $signed({{(MIX_W-THR_W-16){1'b0}}, r_thr1, 16'b0});
    assign roll_q  = $signed({{(MIX_W-AXIS_W){roll_out[AXIS_W-1]}}, roll_out});
    assign pitch_q = $signed({{(MIX_W-AXIS_W){pitch_out[AXIS_W-1]}}, pitch_out});

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            if (r_fly1) begin
                r_m_fl <= motor_of(thr_q - roll_q - pitch_q);
                r_m_rl <= motor_of(thr_q + roll_q - pitch_q);
                r_m_rr <= motor_of(thr_q + roll_q + pitch_q);
                r_m_fr <= motor_of(thr_q - roll_q + pitch_q);
            end else begin
                r_m_fl <= '0;
                r_m_rl <= '0;
                r_m_rr <= '0;
                r_m_fr <= '0;
            end
        end
    end

    assign o_out_valid         = r_v2;
    assign o_motor_front_left  = r_m_fl;
    assign o_motor_rear_left   = r_m_rl;
    assign o_motor_rear_right  = r_m_rr;
    assign o_motor_front_right = r_m_fr;

    assign pipe_full = r_v0 && r_v1 && r_v2;
    assign motors_in_range = (o_motor_front_left <= MOTOR_MAX)
                          && (o_motor_rear_left <= MOTOR_MAX)
                          && (o_motor_rear_right <= MOTOR_MAX)
                          && (o_motor_front_right <= MOTOR_MAX);
    assign motors_off = (o_motor_front_left == '0) && (o_motor_rear_left == '0)
                     && (o_motor_rear_right == '0) && (o_motor_front_right == '0);

    `ASSERT_CLKD(a_motor_range, o_out_valid |-> motors_in_range, "motor command above limit")
    `ASSERT_CLKD(a_stall_full, o_in_stall |-> (pipe_full && i_out_stall), "stall with room")
    `ASSERT_CLKD(a_idle_motors, (adv2 && r_v1 && !r_fly1) |=> motors_off, "motors on grounded")

endmodule
